// ----- rtl/core/pps_pkg.sv -----
// Shared types and constants for the pure pursuit steering block.
// No dependencies; pps_if, pps_ctrl, pps_dp and pure_pursuit_steering refer to this package.

package pps_pkg;

	// Field widths
	localparam int OP_W     = 2;
	localparam int COORD_W  = 32;
	localparam int QUAT_W   = 16;
	localparam int CFG_W    = 31;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;

	// Operation codes of an input word
	localparam logic [OP_W-1:0] OPC_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OPC_QUERY  = 2'd1;
	localparam logic [OP_W-1:0] OPC_CLEAR  = 2'd2;

	// Status codes of a result word
	localparam logic [STATUS_W-1:0] ST_TRACK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_GOAL  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOOK_AHEAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_TOL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LIN    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ANG    = 2'd3;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_LOOK_AHEAD = 31'd32768;
	localparam logic [CFG_W-1:0] RST_GOAL_TOL   = 31'd6554;
	localparam logic [CFG_W-1:0] RST_MAX_LIN    = 31'd19661;
	localparam logic [CFG_W-1:0] RST_MAX_ANG    = 31'd65536;

	// Datapath micro-operations
	typedef enum logic [4:0] {
		DP_NONE,
		DP_APPEND,
		DP_CLEAR,
		DP_LA2,
		DP_G2,
		DP_RD,
		DP_DIFF,
		DP_DIFF_ORG,
		DP_SQX,
		DP_SQY_LA,
		DP_SQY_G,
		DP_QUAT,
		DP_MUL_CDX,
		DP_MAC_SDY,
		DP_MUL_CDY,
		DP_MAC_NSDX,
		DP_DIV_ROT,
		DP_FIN_X,
		DP_FIN_Y,
		DP_SQ_XR,
		DP_SQ_YR,
		DP_MUL_YM,
		DP_DIV_ANG,
		DP_FIN_A,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic [STATUS_W-1:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] opcode;
		logic            empty;
		logic            hit;
		logic            scan_done;
		logic            div_busy;
		logic            ang_en;
		logic            out_free;
	} dp_sts_t;

endpackage

// ----- rtl/core/pps_if.sv -----
// Valid/ready channel interfaces of the pure pursuit steering block.
// Depends on pps_pkg for field widths.

interface pps_req_if;
	logic                                valid;
	logic                                ready;
	logic [pps_pkg::OP_W-1:0]            operation;
	logic signed [pps_pkg::COORD_W-1:0]  pos_x;
	logic signed [pps_pkg::COORD_W-1:0]  pos_y;
	logic signed [pps_pkg::QUAT_W-1:0]   quat_z;
	logic signed [pps_pkg::QUAT_W-1:0]   quat_w;
	modport source(output valid, operation, pos_x, pos_y, quat_z, quat_w, input ready);
	modport sink(input valid, operation, pos_x, pos_y, quat_z, quat_w, output ready);
endinterface

interface pps_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [pps_pkg::STATUS_W-1:0]        status;
	logic [pps_pkg::CFG_W-1:0]           linear_velocity;
	logic signed [pps_pkg::COORD_W-1:0]  angular_velocity;
	logic signed [pps_pkg::COORD_W-1:0]  carrot_x;
	logic signed [pps_pkg::COORD_W-1:0]  carrot_y;
	logic                                path_overflow;
	modport source(output valid, status, linear_velocity, angular_velocity, carrot_x,
		carrot_y, path_overflow, input ready);
	modport sink(input valid, status, linear_velocity, angular_velocity, carrot_x,
		carrot_y, path_overflow, output ready);
endinterface

interface pps_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [pps_pkg::CFG_IDX_W-1:0]       index;
	logic [pps_pkg::CFG_W-1:0]           data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/pure_pursuit_steering.sv -----
// Pure pursuit steering: path store plus carrot search and steering command.
// Append and clear each run one datapath step; a query scans the stored points through the shared
// multiplier and then runs up to three bit-serial divides. One word is in work at a time;
// the next is taken while a finished result waits in the output register.
// Reset clears path length, overflow flag and registers to defaults; point store undefined.

module pure_pursuit_steering #(
	parameter int MAX_PATH_POINTS = 256,
	parameter int COORD_FRAC_BITS = 16
) (
	input logic       clk,
	input logic       arst_n,
	pps_req_if.sink   req,
	pps_rsp_if.source rsp,
	pps_cfg_if.sink   cfg
);

	pps_pkg::dp_cmd_t cmd;
	pps_pkg::dp_sts_t sts;
	logic             req_accept;

	// Accept an input word; configuration is always taken
	assign req_accept = req.valid && req.ready;
	assign cfg.ready  = 1'b1;

	pps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_accept(req_accept), .req_ready(req.ready),
		.cmd(cmd), .sts(sts)
	);

	pps_dp #(
		.MAX_PATH_POINTS(MAX_PATH_POINTS),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.req_accept(req_accept), .req_operation(req.operation),
		.req_pos_x(req.pos_x), .req_pos_y(req.pos_y),
		.req_quat_z(req.quat_z), .req_quat_w(req.quat_w),
		.cfg_write(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.cmd(cmd), .sts(sts),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
		.rsp_linear_velocity(rsp.linear_velocity),
		.rsp_angular_velocity(rsp.angular_velocity),
		.rsp_carrot_x(rsp.carrot_x), .rsp_carrot_y(rsp.carrot_y),
		.rsp_path_overflow(rsp.path_overflow)
	);

endmodule

// ----- rtl/core/pps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module pps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/pps_ctrl.sv -----
// Pure pursuit steering sequencer: at most one micro-operation a cycle.
// Depends on pps_pkg for the command and status types.

module pps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_accept,
	output logic             req_ready,
	output pps_pkg::dp_cmd_t cmd,
	input  pps_pkg::dp_sts_t sts
);

	typedef enum logic [5:0] {
		S_IDLE, S_DEC, S_APPEND, S_CLEAR,
		S_LA2, S_G2, S_RD, S_DIFF, S_SQX, S_SQY, S_CHK,
		S_DORG, S_GSQX, S_GSQY, S_GCHK,
		S_QUAT, S_MCX, S_MSX, S_DVX, S_WX, S_FX,
		S_MCY, S_MSY, S_DVY, S_WY, S_FY,
		S_SQXR, S_SQYR, S_ACHK, S_MYM, S_DVA, S_WA, S_FA,
		S_EMIT
	} state_t;

	state_t                          state_q, nxt;
	pps_pkg::dp_op_t                 op_q;
	logic [pps_pkg::STATUS_W-1:0]    code_q, nxt_code;
	logic                            ready_q;

	// Micro-operation carried out while in a state
	function automatic pps_pkg::dp_op_t op_of(state_t s);
		pps_pkg::dp_op_t o;
		unique case (s)
			S_APPEND: o = pps_pkg::DP_APPEND;
			S_CLEAR:  o = pps_pkg::DP_CLEAR;
			S_LA2:    o = pps_pkg::DP_LA2;
			S_G2:     o = pps_pkg::DP_G2;
			S_RD:     o = pps_pkg::DP_RD;
			S_DIFF:   o = pps_pkg::DP_DIFF;
			S_SQX:    o = pps_pkg::DP_SQX;
			S_SQY:    o = pps_pkg::DP_SQY_LA;
			S_DORG:   o = pps_pkg::DP_DIFF_ORG;
			S_GSQX:   o = pps_pkg::DP_SQX;
			S_GSQY:   o = pps_pkg::DP_SQY_G;
			S_QUAT:   o = pps_pkg::DP_QUAT;
			S_MCX:    o = pps_pkg::DP_MUL_CDX;
			S_MSX:    o = pps_pkg::DP_MAC_SDY;
			S_DVX:    o = pps_pkg::DP_DIV_ROT;
			S_FX:     o = pps_pkg::DP_FIN_X;
			S_MCY:    o = pps_pkg::DP_MUL_CDY;
			S_MSY:    o = pps_pkg::DP_MAC_NSDX;
			S_DVY:    o = pps_pkg::DP_DIV_ROT;
			S_FY:     o = pps_pkg::DP_FIN_Y;
			S_SQXR:   o = pps_pkg::DP_SQ_XR;
			S_SQYR:   o = pps_pkg::DP_SQ_YR;
			S_MYM:    o = pps_pkg::DP_MUL_YM;
			S_DVA:    o = pps_pkg::DP_DIV_ANG;
			S_FA:     o = pps_pkg::DP_FIN_A;
			S_EMIT:   o = pps_pkg::DP_EMIT;
			default:  o = pps_pkg::DP_NONE;
		endcase
		return o;
	endfunction

	// Next state
	always_comb begin
		nxt      = state_q;
		nxt_code = code_q;
		unique case (state_q)
			S_IDLE: if (req_accept) nxt = S_DEC;
			S_DEC: begin
				case (sts.opcode)
					pps_pkg::OPC_APPEND: nxt = S_APPEND;
					pps_pkg::OPC_CLEAR:  nxt = S_CLEAR;
					pps_pkg::OPC_QUERY: begin
						if (sts.empty) begin
							nxt      = S_EMIT;
							nxt_code = pps_pkg::ST_EMPTY;
						end else begin
							nxt = S_LA2;
						end
					end
					default: nxt = S_IDLE;
				endcase
			end
			S_APPEND, S_CLEAR: nxt = S_IDLE;
			S_LA2:  nxt = S_G2;
			S_G2:   nxt = S_RD;
			S_RD:   nxt = S_DIFF;
			S_DIFF: nxt = S_SQX;
			S_SQX:  nxt = S_SQY;
			S_SQY:  nxt = S_CHK;
			S_CHK: begin
				if (sts.hit) nxt = S_GSQX;
				else if (sts.scan_done) nxt = S_DORG;
				else nxt = S_RD;
			end
			S_DORG: nxt = S_GSQX;
			S_GSQX: nxt = S_GSQY;
			S_GSQY: nxt = S_GCHK;
			S_GCHK: begin
				if (sts.hit) begin
					nxt      = S_EMIT;
					nxt_code = pps_pkg::ST_GOAL;
				end else begin
					nxt = S_QUAT;
				end
			end
			S_QUAT: nxt = S_MCX;
			S_MCX:  nxt = S_MSX;
			S_MSX:  nxt = S_DVX;
			S_DVX:  nxt = S_WX;
			S_WX:   if (!sts.div_busy) nxt = S_FX;
			S_FX:   nxt = S_MCY;
			S_MCY:  nxt = S_MSY;
			S_MSY:  nxt = S_DVY;
			S_DVY:  nxt = S_WY;
			S_WY:   if (!sts.div_busy) nxt = S_FY;
			S_FY:   nxt = S_SQXR;
			S_SQXR: nxt = S_SQYR;
			S_SQYR: nxt = S_ACHK;
			S_ACHK: begin
				if (sts.ang_en) begin
					nxt = S_MYM;
				end else begin
					nxt      = S_EMIT;
					nxt_code = pps_pkg::ST_TRACK;
				end
			end
			S_MYM:  nxt = S_DVA;
			S_DVA:  nxt = S_WA;
			S_WA:   if (!sts.div_busy) nxt = S_FA;
			S_FA: begin
				nxt      = S_EMIT;
				nxt_code = pps_pkg::ST_TRACK;
			end
			S_EMIT: if (sts.out_free) nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	// State and registered command outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= pps_pkg::DP_NONE;
			code_q  <= pps_pkg::ST_TRACK;
			ready_q <= 1'b1;
		end else begin
			state_q <= nxt;
			op_q    <= op_of(nxt);
			code_q  <= nxt_code;
			ready_q <= (nxt == S_IDLE);
		end
	end

	assign req_ready = ready_q;
	assign cmd.op    = op_q;
	assign cmd.code  = code_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (state_q == S_IDLE))
		else $error("input ready outside idle");
	a_fin_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FX || state_q == S_FY || state_q == S_FA) |-> !sts.div_busy)
		else $error("quotient taken while divider busy");

endmodule

// ----- rtl/core/pps_dp.sv -----
// Datapath of the pure pursuit steering block: path store, shared multiplier,
// bit-serial divider, configuration and result registers.
// Depends on pps_pkg and pps_ram.

module pps_dp #(
	parameter int MAX_PATH_POINTS = 256,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_accept,
	input  logic [pps_pkg::OP_W-1:0]            req_operation,
	input  logic signed [pps_pkg::COORD_W-1:0]  req_pos_x,
	input  logic signed [pps_pkg::COORD_W-1:0]  req_pos_y,
	input  logic signed [pps_pkg::QUAT_W-1:0]   req_quat_z,
	input  logic signed [pps_pkg::QUAT_W-1:0]   req_quat_w,
	input  logic                                cfg_write,
	input  logic [pps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pps_pkg::CFG_W-1:0]           cfg_data,
	input  pps_pkg::dp_cmd_t                    cmd,
	output pps_pkg::dp_sts_t                    sts,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [pps_pkg::STATUS_W-1:0]        rsp_status,
	output logic [pps_pkg::CFG_W-1:0]           rsp_linear_velocity,
	output logic signed [pps_pkg::COORD_W-1:0]  rsp_angular_velocity,
	output logic signed [pps_pkg::COORD_W-1:0]  rsp_carrot_x,
	output logic signed [pps_pkg::COORD_W-1:0]  rsp_carrot_y,
	output logic                                rsp_path_overflow
);

	localparam int AW = $clog2(MAX_PATH_POINTS);
	localparam int LW = $clog2(MAX_PATH_POINTS + 1);
	localparam int DW = COORD_FRAC_BITS + 64;
	localparam int SH = COORD_FRAC_BITS + 1;
	localparam int CW = $clog2(DW + 1);
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATH_POINTS);
	localparam logic [63:0] CURV_THR =
		((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd500) / 64'd1000;

	// Configuration
	logic [30:0] la_q, gt_q, mlv_q, mav_q;
	// Captured input word
	logic [1:0]         opc_q;
	logic signed [31:0] rx_q, ry_q;
	logic signed [15:0] qz_q, qw_q;
	// Path bookkeeping
	logic [LW-1:0] len_q, idx_q;
	logic          ovf_q;
	// Working registers
	logic signed [32:0] dx_q, dy_q, c_q, s_q;
	logic [31:0]        d_q;
	logic               big_q, hit_q;
	logic [63:0]        sq_q, la2_q, g2_q, d2r_q;
	logic signed [67:0] acc_q;
	logic signed [31:0] xr_q, yr_q, ang_q;
	// Divider
	logic [DW-1:0] dnum_q, quo_q;
	logic [63:0]   den_q;
	logic [64:0]   rem_q;
	logic [CW-1:0] dcnt_q;
	logic          dbusy_q, dneg_q;
	// Output register
	logic        ov_q;
	logic [1:0]  ost_q;
	logic [30:0] olin_q;
	logic signed [31:0] oang_q, ocx_q, ocy_q;
	logic        oovf_q;

	logic [31:0] ram_x, ram_y;
	logic        wr_en;
	logic        out_free;

	assign wr_en    = (cmd.op == pps_pkg::DP_APPEND) && (len_q != MAX_LEN);
	assign out_free = !ov_q || rsp_ready;

	pps_ram #(.WIDTH(32), .DEPTH(MAX_PATH_POINTS)) u_path_x (
		.clk(clk), .wr_en(wr_en), .wr_addr(len_q[AW-1:0]), .wr_data(rx_q),
		.rd_en(cmd.op == pps_pkg::DP_RD), .rd_addr(idx_q[AW-1:0]), .rd_data(ram_x)
	);
	pps_ram #(.WIDTH(32), .DEPTH(MAX_PATH_POINTS)) u_path_y (
		.clk(clk), .wr_en(wr_en), .wr_addr(len_q[AW-1:0]), .wr_data(ry_q),
		.rd_en(cmd.op == pps_pkg::DP_RD), .rd_addr(idx_q[AW-1:0]), .rd_data(ram_y)
	);

	// Magnitudes of offsets and rotated carrot
	logic [32:0] ax, ay;
	logic [31:0] xm, ym;
	logic [67:0] acc_mag;
	assign ax      = dx_q[32] ? (~dx_q + 33'd1) : dx_q;
	assign ay      = dy_q[32] ? (~dy_q + 33'd1) : dy_q;
	assign xm      = xr_q[31] ? (~xr_q + 32'd1) : xr_q;
	assign ym      = yr_q[31] ? (~yr_q + 32'd1) : yr_q;
	assign acc_mag = acc_q[67] ? (~acc_q + 68'd1) : acc_q;

	// Shared multiplier operand select
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] prod;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			pps_pkg::DP_LA2: begin
				mul_a = {3'b0, la_q}; mul_b = {3'b0, la_q};
			end
			pps_pkg::DP_G2: begin
				mul_a = {3'b0, gt_q}; mul_b = {3'b0, gt_q};
			end
			pps_pkg::DP_SQX: begin
				mul_a = {3'b0, ax[30:0]}; mul_b = {3'b0, ax[30:0]};
			end
			pps_pkg::DP_SQY_LA, pps_pkg::DP_SQY_G: begin
				mul_a = {3'b0, ay[30:0]}; mul_b = {3'b0, ay[30:0]};
			end
			pps_pkg::DP_MUL_CDX: begin
				mul_a = {c_q[32], c_q}; mul_b = {dx_q[32], dx_q};
			end
			pps_pkg::DP_MAC_SDY: begin
				mul_a = {s_q[32], s_q}; mul_b = {dy_q[32], dy_q};
			end
			pps_pkg::DP_MUL_CDY: begin
				mul_a = {c_q[32], c_q}; mul_b = {dy_q[32], dy_q};
			end
			pps_pkg::DP_MAC_NSDX: begin
				mul_a = {s_q[32], s_q}; mul_b = {dx_q[32], dx_q};
			end
			pps_pkg::DP_SQ_XR: begin
				mul_a = {2'b0, xm}; mul_b = {2'b0, xm};
			end
			pps_pkg::DP_SQ_YR: begin
				mul_a = {2'b0, ym}; mul_b = {2'b0, ym};
			end
			pps_pkg::DP_MUL_YM: begin
				mul_a = {2'b0, ym}; mul_b = {3'b0, mav_q};
			end
			default: ;
		endcase
	end
	assign prod = mul_a * mul_b;

	// Rotation terms from the quaternion
	logic signed [31:0] ww, zz, wz;
	logic signed [32:0] c_n, s_n;
	logic [31:0]        d_n;
	always_comb begin
		ww  = qw_q * qw_q;
		zz  = qz_q * qz_q;
		wz  = qw_q * qz_q;
		c_n = {ww[31], ww} - {zz[31], zz};
		s_n = {wz, 1'b0};
		d_n = ww + zz;
		// zero quaternion acts as identity
		if (d_n == 32'd0) begin
			c_n = 33'sd1;
			s_n = 33'sd0;
			d_n = 32'd1;
		end
	end

	// Divider step and rounded, saturated quotient
	logic [64:0] rem_sh;
	logic        rem_ge, rnd;
	logic [DW:0] qf;
	logic [31:0] qsat;
	assign rem_sh = {rem_q[63:0], dnum_q[DW-1]};
	assign rem_ge = rem_sh >= {1'b0, den_q};
	assign rnd    = {rem_q, 1'b0} >= {2'b0, den_q};
	assign qf     = {1'b0, quo_q} + (DW+1)'(rnd);
	always_comb begin
		if (dneg_q) begin
			qsat = (|qf[DW:31]) ? 32'h8000_0000 : (~qf[31:0] + 32'd1);
		end else begin
			qsat = (|qf[DW:31]) ? 32'h7FFF_FFFF : qf[31:0];
		end
	end

	logic [63:0] d2_sum;
	assign d2_sum = sq_q + prod[63:0];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_q  <= pps_pkg::RST_LOOK_AHEAD;
			gt_q  <= pps_pkg::RST_GOAL_TOL;
			mlv_q <= pps_pkg::RST_MAX_LIN;
			mav_q <= pps_pkg::RST_MAX_ANG;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pps_pkg::REG_LOOK_AHEAD: la_q  <= cfg_data;
				pps_pkg::REG_GOAL_TOL:   gt_q  <= cfg_data;
				pps_pkg::REG_MAX_LIN:    mlv_q <= cfg_data;
				pps_pkg::REG_MAX_ANG:    mav_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Path length, overflow flag, divider and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			dbusy_q <= 1'b0;
			dcnt_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (cmd.op == pps_pkg::DP_APPEND) begin
				if (len_q != MAX_LEN) len_q <= len_q + LW'(1);
				else ovf_q <= 1'b1;
			end else if (cmd.op == pps_pkg::DP_CLEAR) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end
			if (cmd.op == pps_pkg::DP_DIV_ROT || cmd.op == pps_pkg::DP_DIV_ANG) begin
				dbusy_q <= 1'b1;
				dcnt_q  <= CW'(DW);
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q - CW'(1);
				if (dcnt_q == CW'(1)) dbusy_q <= 1'b0;
			end
			if (cmd.op == pps_pkg::DP_EMIT && out_free) ov_q <= 1'b1;
			else if (rsp_ready) ov_q <= 1'b0;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (req_accept) begin
			opc_q <= req_operation;
			rx_q  <= req_pos_x;
			ry_q  <= req_pos_y;
			qz_q  <= req_quat_z;
			qw_q  <= req_quat_w;
		end
		case (cmd.op)
			pps_pkg::DP_LA2: begin
				la2_q <= prod[63:0];
				idx_q <= '0;
				hit_q <= 1'b0;
				ang_q <= '0;
			end
			pps_pkg::DP_G2: g2_q <= prod[63:0];
			pps_pkg::DP_DIFF: begin
				dx_q <= {ram_x[31], ram_x} - {rx_q[31], rx_q};
				dy_q <= {ram_y[31], ram_y} - {ry_q[31], ry_q};
			end
			pps_pkg::DP_DIFF_ORG: begin
				dx_q <= 33'sd0 - {rx_q[31], rx_q};
				dy_q <= 33'sd0 - {ry_q[31], ry_q};
			end
			pps_pkg::DP_SQX: begin
				sq_q  <= prod[63:0];
				big_q <= ax[32] | ax[31];
			end
			pps_pkg::DP_SQY_LA: begin
				hit_q <= !big_q && !(ay[32] | ay[31]) && (d2_sum < la2_q);
				idx_q <= idx_q + LW'(1);
			end
			pps_pkg::DP_SQY_G:
				hit_q <= !big_q && !(ay[32] | ay[31]) && (d2_sum <= g2_q);
			pps_pkg::DP_QUAT: begin
				c_q <= c_n;
				s_q <= s_n;
				d_q <= d_n;
			end
			pps_pkg::DP_MUL_CDX, pps_pkg::DP_MUL_CDY, pps_pkg::DP_MUL_YM: acc_q <= prod;
			pps_pkg::DP_MAC_SDY:  acc_q <= acc_q + prod;
			pps_pkg::DP_MAC_NSDX: acc_q <= acc_q - prod;
			pps_pkg::DP_FIN_X: xr_q  <= qsat;
			pps_pkg::DP_FIN_Y: yr_q  <= qsat;
			pps_pkg::DP_FIN_A: ang_q <= qsat;
			pps_pkg::DP_SQ_XR: sq_q  <= prod[63:0];
			pps_pkg::DP_SQ_YR: d2r_q <= d2_sum;
			default: ;
		endcase
		// load or advance the divider
		if (cmd.op == pps_pkg::DP_DIV_ROT) begin
			dnum_q <= DW'(acc_mag[64:0]);
			den_q  <= {32'd0, d_q};
			dneg_q <= acc_q[67];
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (cmd.op == pps_pkg::DP_DIV_ANG) begin
			dnum_q <= DW'({acc_q[61:0], {SH{1'b0}}});
			den_q  <= d2r_q;
			dneg_q <= yr_q[31];
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (dbusy_q) begin
			rem_q  <= rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q  <= {quo_q[DW-2:0], rem_ge};
			dnum_q <= {dnum_q[DW-2:0], 1'b0};
		end
		// capture the result word
		if (cmd.op == pps_pkg::DP_EMIT && out_free) begin
			ost_q  <= cmd.code;
			oovf_q <= ovf_q;
			if (cmd.code == pps_pkg::ST_TRACK) begin
				olin_q <= mlv_q;
				oang_q <= ang_q;
				ocx_q  <= xr_q;
				ocy_q  <= yr_q;
			end else begin
				olin_q <= '0;
				oang_q <= '0;
				ocx_q  <= '0;
				ocy_q  <= '0;
			end
		end
	end

	assign sts.opcode    = opc_q;
	assign sts.empty     = (len_q == '0);
	assign sts.hit       = hit_q;
	assign sts.scan_done = (idx_q == len_q);
	assign sts.div_busy  = dbusy_q;
	assign sts.ang_en    = (d2r_q > CURV_THR) && (yr_q != 32'sd0);
	assign sts.out_free  = out_free;

	assign rsp_valid            = ov_q;
	assign rsp_status           = ost_q;
	assign rsp_linear_velocity  = olin_q;
	assign rsp_angular_velocity = oang_q;
	assign rsp_carrot_x         = ocx_q;
	assign rsp_carrot_y         = ocy_q;
	assign rsp_path_overflow    = oovf_q;

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == MAX_LEN))
		else $error("overflow flag set with room in path");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pps_pkg::DP_DIV_ROT || cmd.op == pps_pkg::DP_DIV_ANG) |-> !dbusy_q)
		else $error("divider restarted while busy");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		dbusy_q |-> (dcnt_q != '0))
		else $error("divider busy with zero count");

endmodule
